### hw/rtl/repeating_timer_scheduler_assert.svh
// ----------------------------------------------------------------------------
// repeating_timer_scheduler_assert
// assertion macros for the repeating timer scheduler
// ----------------------------------------------------------------------------
`ifndef REPEATING_TIMER_SCHEDULER_ASSERT_SVH
`define REPEATING_TIMER_SCHEDULER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rts assertion failed");

// next-cycle implication, checked out of reset
`define RTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rts assertion failed");

`endif

### hw/rtl/rts_pkg.sv
// ----------------------------------------------------------------------------
// rts_pkg
// shared types and constants of the repeating timer scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package rts_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_W      = $clog2(TIMER_SLOTS);
  localparam int DL_W        = 49;
  localparam int NOW_W       = 48;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_CHECK  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REPLACED = 2'd1,
    ST_UNKNOWN  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  localparam logic KIND_FIRED  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    op_t          op;
    logic [31:0]  owner;
    logic [30:0]  session;
    logic [15:0]  count;
    logic [31:0]  period;
    logic [NOW_W-1:0] now;
  } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/rts_front.sv
// ----------------------------------------------------------------------------
// rts_front
// takes commands, decodes them and holds them in a short queue
// ----------------------------------------------------------------------------
`default_nettype none

module rts_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [1:0]    in_operation,
  input  wire logic [31:0]   in_owner_handle,
  input  wire logic [30:0]   in_session_id,
  input  wire logic [15:0]   in_repeat_count,
  input  wire logic [31:0]   in_interval_ms,
  input  wire logic [47:0]   in_now_ms,
  output logic               q_valid,
  output rts_pkg::cmd_t      q_cmd,
  input  wire logic          q_pop
);
  import rts_pkg::*;

  cmd_t                 q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic                 push;
  logic                 pop;
  cmd_t                 dec;

  assign busy    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign pop     = q_pop && q_valid;
  assign q_cmd   = q_mem[rd_ptr_r];

  // zero interval runs as one millisecond
  always_comb begin
    dec.op      = op_t'(in_operation);
    dec.owner   = in_owner_handle;
    dec.session = in_session_id;
    dec.count   = in_repeat_count;
    dec.period  = (in_interval_ms == '0) ? 32'd1 : in_interval_ms;
    dec.now     = in_now_ms;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rts_back.sv
// ----------------------------------------------------------------------------
// rts_back
// slot table and the sequencer that carries out queued commands
// ----------------------------------------------------------------------------
`default_nettype none

module rts_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire rts_pkg::cmd_t q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  output logic               out_kind,
  output logic [31:0]        out_fired_handle,
  output logic [30:0]        out_fired_session,
  output logic [31:0]        out_gap_ms,
  output logic               out_any_pending,
  output logic [1:0]         out_status,
  output logic               out_last
);
  import rts_pkg::*;

  localparam logic [SLOT_W-1:0] IDX_LAST = SLOT_W'(TIMER_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_KEY_SCAN, S_APPLY, S_GAP_SCAN, S_CLEAR, S_PICK_SCAN, S_FIRE, S_REPORT
  } state_t;

  // slot payload
  logic [31:0]     owner_mem  [TIMER_SLOTS];
  logic [30:0]     sess_mem   [TIMER_SLOTS];
  logic [15:0]     rem_mem    [TIMER_SLOTS];
  logic [31:0]     per_mem    [TIMER_SLOTS];
  logic [DL_W-1:0] dl_mem     [TIMER_SLOTS];

  state_t                  state_r, state_nxt;
  cmd_t                    cmd_r, cmd_nxt;
  logic [TIMER_SLOTS-1:0]  valid_r, valid_nxt;
  logic [TIMER_SLOTS-1:0]  canc_r, canc_nxt;
  logic [TIMER_SLOTS-1:0]  keyed_r, keyed_nxt;
  logic [SLOT_W-1:0]       idx_r, idx_nxt;
  logic                    old_found_r, old_found_nxt;
  logic [SLOT_W-1:0]       old_r, old_nxt;
  logic                    free_found_r, free_found_nxt;
  logic [SLOT_W-1:0]       free_r, free_nxt;
  logic                    best_found_r, best_found_nxt;
  logic [DL_W-1:0]         best_r, best_nxt;
  logic                    due_found_r, due_found_nxt;
  logic [DL_W-1:0]         due_r, due_nxt;
  logic [SLOT_W-1:0]       pick_r, pick_nxt;
  logic [31:0]             pk_owner_r, pk_owner_nxt;
  logic [30:0]             pk_sess_r, pk_sess_nxt;
  logic [15:0]             pk_rem_r, pk_rem_nxt;
  logic [31:0]             pk_per_r, pk_per_nxt;
  logic [1:0]              st_r, st_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_kind_r, out_kind_nxt;
  logic [31:0]             out_handle_r, out_handle_nxt;
  logic [30:0]             out_sess_r, out_sess_nxt;
  logic [31:0]             out_gap_r, out_gap_nxt;
  logic                    out_any_r, out_any_nxt;
  logic [1:0]              out_status_r, out_status_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    add_we, fire_rem_we, fire_dl_we;
  logic                    cur_live;
  logic [DL_W-1:0]         cur_dl;
  logic [DL_W-1:0]         now_x;
  logic [DL_W-1:0]         gap_diff;
  logic [15:0]             rem_dec;
  logic                    any_live;

  assign cur_live = valid_r[idx_r] && !canc_r[idx_r];
  assign cur_dl   = dl_mem[idx_r];
  assign now_x    = {1'b0, cmd_r.now};
  assign gap_diff = best_r - now_x;
  assign rem_dec  = pk_rem_r - 16'd1;
  assign any_live = |(valid_r & ~canc_r);
  assign q_pop    = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    valid_nxt      = valid_r;
    canc_nxt       = canc_r;
    keyed_nxt      = keyed_r;
    idx_nxt        = idx_r;
    old_found_nxt  = old_found_r;
    old_nxt        = old_r;
    free_found_nxt = free_found_r;
    free_nxt       = free_r;
    best_found_nxt = best_found_r;
    best_nxt       = best_r;
    due_found_nxt  = due_found_r;
    due_nxt        = due_r;
    pick_nxt       = pick_r;
    pk_owner_nxt   = pk_owner_r;
    pk_sess_nxt    = pk_sess_r;
    pk_rem_nxt     = pk_rem_r;
    pk_per_nxt     = pk_per_r;
    st_nxt         = st_r;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = KIND_STATUS;
    out_handle_nxt = '0;
    out_sess_nxt   = '0;
    out_gap_nxt    = '0;
    out_any_nxt    = 1'b0;
    out_status_nxt = ST_OK;
    out_last_nxt   = 1'b0;
    add_we         = 1'b0;
    fire_rem_we    = 1'b0;
    fire_dl_we     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          cmd_nxt        = q_cmd;
          idx_nxt        = '0;
          old_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          best_found_nxt = 1'b0;
          due_found_nxt  = 1'b0;
          st_nxt         = ST_OK;
          case (q_cmd.op)
            OP_ADD, OP_CANCEL: state_nxt = S_KEY_SCAN;
            OP_CHECK:          state_nxt = S_CLEAR;
            default:           state_nxt = S_REPORT;
          endcase
        end
      end

      // look for the keyed slot of the session and the first free slot
      S_KEY_SCAN: begin
        if (!old_found_r && valid_r[idx_r] && keyed_r[idx_r] &&
            sess_mem[idx_r] == cmd_r.session) begin
          old_found_nxt = 1'b1;
          old_nxt       = idx_r;
        end
        if (!free_found_r && !valid_r[idx_r]) begin
          free_found_nxt = 1'b1;
          free_nxt       = idx_r;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_LAST) begin
          state_nxt = S_APPLY;
        end
      end

      S_APPLY: begin
        idx_nxt = '0;
        if (cmd_r.op == OP_ADD) begin
          state_nxt = S_GAP_SCAN;
          if (!free_found_r) begin
            st_nxt = ST_FULL;
          end else begin
            if (old_found_r) begin
              canc_nxt[old_r]  = 1'b1;
              keyed_nxt[old_r] = 1'b0;
              st_nxt           = ST_REPLACED;
            end
            valid_nxt[free_r] = 1'b1;
            canc_nxt[free_r]  = 1'b0;
            keyed_nxt[free_r] = 1'b1;
            add_we            = 1'b1;
          end
        end else begin
          state_nxt = S_REPORT;
          if (old_found_r) begin
            canc_nxt[old_r] = 1'b1;
            st_nxt          = ST_OK;
          end else begin
            st_nxt = ST_UNKNOWN;
          end
        end
      end

      // earliest live deadline after an add
      S_GAP_SCAN: begin
        if (cur_live && (!best_found_r || cur_dl < best_r)) begin
          best_found_nxt = 1'b1;
          best_nxt       = cur_dl;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_LAST) begin
          state_nxt = S_REPORT;
        end
      end

      // free every cancelled slot at once
      S_CLEAR: begin
        valid_nxt = valid_r & ~canc_r;
        keyed_nxt = keyed_r & ~(valid_r & canc_r);
        canc_nxt  = '0;
        idx_nxt   = '0;
        state_nxt = S_PICK_SCAN;
      end

      // one pass finds the earliest due timer and the earliest live deadline
      S_PICK_SCAN: begin
        if (cur_live && (!best_found_r || cur_dl < best_r)) begin
          best_found_nxt = 1'b1;
          best_nxt       = cur_dl;
        end
        if (cur_live && cur_dl <= now_x && (!due_found_r || cur_dl < due_r)) begin
          due_found_nxt = 1'b1;
          due_nxt       = cur_dl;
          pick_nxt      = idx_r;
          pk_owner_nxt  = owner_mem[idx_r];
          pk_sess_nxt   = sess_mem[idx_r];
          pk_rem_nxt    = rem_mem[idx_r];
          pk_per_nxt    = per_mem[idx_r];
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_LAST) begin
          state_nxt = due_found_nxt ? S_FIRE : S_REPORT;
        end
      end

      S_FIRE: begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = KIND_FIRED;
        out_handle_nxt = pk_owner_r;
        out_sess_nxt   = pk_sess_r;
        if (pk_rem_r != '0) begin
          fire_rem_we = 1'b1;
        end
        if (pk_rem_r == 16'd1) begin
          valid_nxt[pick_r] = 1'b0;
          keyed_nxt[pick_r] = 1'b0;
        end else begin
          fire_dl_we = 1'b1;
        end
        idx_nxt        = '0;
        best_found_nxt = 1'b0;
        due_found_nxt  = 1'b0;
        state_nxt      = S_PICK_SCAN;
      end

      S_REPORT: begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = KIND_STATUS;
        out_any_nxt    = any_live;
        out_status_nxt = st_r;
        out_last_nxt   = 1'b1;
        if ((cmd_r.op == OP_ADD || cmd_r.op == OP_CHECK) && best_found_r &&
            best_r > now_x) begin
          out_gap_nxt = (gap_diff[DL_W-1:32] != '0) ? 32'hFFFF_FFFF : gap_diff[31:0];
        end
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // slot payload writes
  always_ff @(posedge clk) begin
    if (add_we) begin
      owner_mem[free_r] <= cmd_r.owner;
      sess_mem[free_r]  <= cmd_r.session;
      rem_mem[free_r]   <= cmd_r.count;
      per_mem[free_r]   <= cmd_r.period;
      dl_mem[free_r]    <= now_x + {{(DL_W-32){1'b0}}, cmd_r.period};
    end else begin
      if (fire_rem_we) begin
        rem_mem[pick_r] <= rem_dec;
      end
      if (fire_dl_we) begin
        dl_mem[pick_r] <= now_x + {{(DL_W-32){1'b0}}, pk_per_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      canc_r      <= '0;
      keyed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      canc_r      <= canc_nxt;
      keyed_r     <= keyed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    old_found_r  <= old_found_nxt;
    old_r        <= old_nxt;
    free_found_r <= free_found_nxt;
    free_r       <= free_nxt;
    best_found_r <= best_found_nxt;
    best_r       <= best_nxt;
    due_found_r  <= due_found_nxt;
    due_r        <= due_nxt;
    pick_r       <= pick_nxt;
    pk_owner_r   <= pk_owner_nxt;
    pk_sess_r    <= pk_sess_nxt;
    pk_rem_r     <= pk_rem_nxt;
    pk_per_r     <= pk_per_nxt;
    st_r         <= st_nxt;
    out_kind_r   <= out_kind_nxt;
    out_handle_r <= out_handle_nxt;
    out_sess_r   <= out_sess_nxt;
    out_gap_r    <= out_gap_nxt;
    out_any_r    <= out_any_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_fired_handle  = out_handle_r;
  assign out_fired_session = out_sess_r;
  assign out_gap_ms        = out_gap_r;
  assign out_any_pending   = out_any_r;
  assign out_status        = out_status_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

### hw/rtl/repeating_timer_scheduler.sv
// add runs key scan, apply, gap scan and report; cancel runs key scan, apply and report;
// check runs clear, then a pick scan and a fire per due timer, a last pick scan and report
// throughput: one transaction at a time in the back end, paced by its one-slot-per-cycle scan
// a two-entry command queue keeps start open while the back end works
// rst_n is synchronous: it empties the queue and frees every slot
// each result is strobed for one cycle on out_valid; the receiver cannot stall
// ----------------------------------------------------------------------------
// repeating_timer_scheduler
// session-keyed table of repeating software timers with earliest-first firing
// ----------------------------------------------------------------------------
`default_nettype none

`include "repeating_timer_scheduler_assert.svh"

module repeating_timer_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command transaction
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_operation,
  input  wire logic [31:0] in_owner_handle,
  input  wire logic [30:0] in_session_id,
  input  wire logic [15:0] in_repeat_count,
  input  wire logic [31:0] in_interval_ms,
  input  wire logic [47:0] in_now_ms,
  // result transaction
  output logic             out_valid,
  output logic             out_kind,
  output logic [31:0]      out_fired_handle,
  output logic [30:0]      out_fired_session,
  output logic [31:0]      out_gap_ms,
  output logic             out_any_pending,
  output logic [1:0]       out_status,
  output logic             out_last
);
  import rts_pkg::*;

  // queue between the decode front and the slot sequencer
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  // front: accepts a transaction, normalizes the interval, queues it
  rts_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_owner_handle (in_owner_handle),
    .in_session_id   (in_session_id),
    .in_repeat_count (in_repeat_count),
    .in_interval_ms  (in_interval_ms),
    .in_now_ms       (in_now_ms),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop)
  );

  // back: scans the slot table, fires due timers, reports status
  rts_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_fired_handle  (out_fired_handle),
    .out_fired_session (out_fired_session),
    .out_gap_ms        (out_gap_ms),
    .out_any_pending   (out_any_pending),
    .out_status        (out_status),
    .out_last          (out_last)
  );

  // a fired notice never closes a transaction
  `RTS_ASSERT_NOW(a_fired_not_last, out_valid && out_kind == KIND_FIRED, !out_last)
  // an accepted command is waiting in the queue on the next cycle
  `RTS_ASSERT_NEXT(a_push_queued, start && !busy, q_valid)
  // the back end returns to idle after the closing status
  `RTS_ASSERT_NEXT(a_gap_after_last, out_valid && out_last, !out_valid)

endmodule

`default_nettype wire

### tb/tb_repeating_timer_scheduler.sv
// ----------------------------------------------------------------------------
// tb_repeating_timer_scheduler
// self-checking bench: predicts fired notices and status per command, compares
// ----------------------------------------------------------------------------
`default_nettype none

module tb_repeating_timer_scheduler;
  import rts_pkg::*;

  localparam int NSLOT = TIMER_SLOTS;

  // one result transaction as predicted
  typedef struct packed {
    logic        kind;
    logic [31:0] handle;
    logic [30:0] session;
    logic [31:0] gap;
    logic        any;
    logic [1:0]  status;
    logic        last;
  } notice_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_operation = '0;
  logic [31:0] in_owner_handle = '0;
  logic [30:0] in_session_id = '0;
  logic [15:0] in_repeat_count = '0;
  logic [31:0] in_interval_ms = '0;
  logic [47:0] in_now_ms = '0;
  logic        out_valid;
  logic        out_kind;
  logic [31:0] out_fired_handle;
  logic [30:0] out_fired_session;
  logic [31:0] out_gap_ms;
  logic        out_any_pending;
  logic [1:0]  out_status;
  logic        out_last;

  repeating_timer_scheduler uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_owner_handle(in_owner_handle),
    .in_session_id(in_session_id), .in_repeat_count(in_repeat_count),
    .in_interval_ms(in_interval_ms), .in_now_ms(in_now_ms),
    .out_valid(out_valid), .out_kind(out_kind), .out_fired_handle(out_fired_handle),
    .out_fired_session(out_fired_session), .out_gap_ms(out_gap_ms),
    .out_any_pending(out_any_pending), .out_status(out_status), .out_last(out_last)
  );

  always #1 clk = ~clk;

  // predictor copy of the timer table
  logic        tv_valid [NSLOT];
  logic        tv_cancel[NSLOT];
  logic        tv_keyed [NSLOT];
  logic [31:0] tv_owner [NSLOT];
  logic [30:0] tv_sess  [NSLOT];
  logic [15:0] tv_left  [NSLOT];
  logic [31:0] tv_period[NSLOT];
  logic [48:0] tv_due   [NSLOT];

  cmd_t    pending_cmds[$];
  notice_t expected_notices[$];
  int      error_count = 0;
  bit      stim_done = 1'b0;
  bit      hold_off = 1'b0;   // sender pause until drained
  bit      no_idle = 1'b0;    // last part of the run
  int      idle_left = 0;

  function automatic bit is_live(int i);
    return tv_valid[i] && !tv_cancel[i];
  endfunction

  function automatic logic any_live();
    foreach (tv_valid[i]) if (is_live(i)) return 1'b1;
    return 1'b0;
  endfunction

  // time to earliest live deadline, saturated
  function automatic logic [31:0] gap_from(logic [47:0] now);
    bit found;
    logic [48:0] best;
    found = 0;
    best = '0;
    foreach (tv_valid[i])
      if (is_live(i) && (!found || tv_due[i] < best)) begin
        best = tv_due[i];
        found = 1;
      end
    if (!found || best <= {1'b0, now}) return '0;
    if (best - {1'b0, now} > 49'hFFFF_FFFF) return 32'hFFFF_FFFF;
    return 32'(best - {1'b0, now});
  endfunction

  function automatic int keyed_slot(logic [30:0] s);
    foreach (tv_valid[i]) if (tv_valid[i] && tv_keyed[i] && tv_sess[i] == s) return i;
    return -1;
  endfunction

  function automatic notice_t status_notice(logic [31:0] gap, logic [1:0] st);
    notice_t n;
    n = '{KIND_STATUS, 32'd0, 31'd0, gap, any_live(), st, 1'b1};
    return n;
  endfunction

  // apply one command to the table and queue its results
  task automatic predict_command(cmd_t c);
    int old, fr, pick;
    logic [1:0] st;
    logic [31:0] per;
    notice_t n;
    case (c.op)
      OP_ADD: begin
        old = keyed_slot(c.session);
        fr = -1;
        for (int i = 0; i < NSLOT; i++) if (!tv_valid[i]) begin fr = i; break; end
        if (fr < 0) begin
          st = ST_FULL;
        end else begin
          st = ST_OK;
          if (old >= 0) begin
            tv_cancel[old] = 1; tv_keyed[old] = 0; st = ST_REPLACED;
          end
          per = (c.period == 0) ? 32'd1 : c.period;
          tv_valid[fr] = 1; tv_cancel[fr] = 0; tv_keyed[fr] = 1;
          tv_owner[fr] = c.owner; tv_sess[fr] = c.session; tv_left[fr] = c.count;
          tv_period[fr] = per; tv_due[fr] = {1'b0, c.now} + per;
        end
        expected_notices.push_back(status_notice(gap_from(c.now), st));
      end
      OP_CANCEL: begin
        old = keyed_slot(c.session);
        st = ST_UNKNOWN;
        if (old >= 0) begin tv_cancel[old] = 1; st = ST_OK; end
        expected_notices.push_back(status_notice('0, st));
      end
      OP_CHECK: begin
        foreach (tv_valid[i])
          if (tv_valid[i] && tv_cancel[i]) begin
            tv_valid[i] = 0; tv_cancel[i] = 0; tv_keyed[i] = 0;
          end
        forever begin
          pick = -1;
          for (int i = 0; i < NSLOT; i++)
            if (is_live(i) && tv_due[i] <= {1'b0, c.now} &&
                (pick < 0 || tv_due[i] < tv_due[pick])) pick = i;
          if (pick < 0) break;
          n = '{KIND_FIRED, tv_owner[pick], tv_sess[pick], 32'd0, 1'b0, ST_OK, 1'b0};
          expected_notices.push_back(n);
          if (tv_left[pick] == 1) begin
            tv_valid[pick] = 0; tv_keyed[pick] = 0;
          end else begin
            if (tv_left[pick] > 0) tv_left[pick]--;
            tv_due[pick] = {1'b0, c.now} + tv_period[pick];
          end
        end
        expected_notices.push_back(status_notice(gap_from(c.now), ST_OK));
      end
      default: expected_notices.push_back(status_notice('0, ST_OK));
    endcase
  endtask

  task automatic report_mismatch(string what);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // driver: start held while transactions are waiting, random idle bursts
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) predict_command({op_t'(in_operation), in_owner_handle,
          in_session_id, in_repeat_count, in_interval_ms, in_now_ms});
      if (!(start && busy)) begin
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
          start <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
          idle_left <= $urandom_range(0, 4);
          start <= 1'b0;
        end else if (pending_cmds.size() > 0 && !hold_off) begin
          start <= 1'b1;
          {in_operation, in_owner_handle, in_session_id, in_repeat_count,
           in_interval_ms, in_now_ms} <= pending_cmds.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result is checked against the oldest prediction
  always @(posedge clk) begin
    notice_t got, exp_n;
    if (rst_n && out_valid) begin
      got = '{out_kind, out_fired_handle, out_fired_session, out_gap_ms,
              out_any_pending, out_status, out_last};
      if (expected_notices.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        exp_n = expected_notices.pop_front();
        if (got.kind !== exp_n.kind) report_mismatch("kind");
        if (got.handle !== exp_n.handle) report_mismatch("fired_handle");
        if (got.session !== exp_n.session) report_mismatch("fired_session");
        if (got.gap !== exp_n.gap) report_mismatch("gap_ms");
        if (got.any !== exp_n.any) report_mismatch("any_pending");
        if (got.status !== exp_n.status) report_mismatch("status");
        if (got.last !== exp_n.last) report_mismatch("last");
      end
    end
  end

  function automatic cmd_t mk(op_t op, logic [31:0] own, logic [30:0] s,
                              logic [15:0] cnt, logic [31:0] per, logic [47:0] now);
    cmd_t c;
    c = '{op, own, s, cnt, per, now};
    return c;
  endfunction

  // random command around a moving clock, small session pool for collisions
  logic [47:0] clock_ms;
  function automatic cmd_t random_cmd();
    int r;
    logic [31:0] per;
    logic [30:0] s;
    r = $urandom_range(0, 99);
    s = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 23));
    per = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 40));
    if ($urandom_range(0, 29) == 0) clock_ms = 48'({$urandom, $urandom} >> 16);
    else clock_ms = clock_ms + 48'($urandom_range(0, 25));
    if (r < 45)
      return mk(OP_ADD, $urandom, s, ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                16'($urandom_range(0, 4)), per, clock_ms);
    if (r < 65) return mk(OP_CANCEL, $urandom, s, 16'($urandom), $urandom,
                          48'({$urandom, $urandom}));
    if (r < 97) return mk(OP_CHECK, $urandom, 31'($urandom), 16'($urandom), $urandom,
                          clock_ms);
    return mk(OP_NOP, $urandom, 31'($urandom), 16'($urandom), $urandom,
              48'({$urandom, $urandom}));
  endfunction

  initial begin
    foreach (tv_valid[i]) begin
      tv_valid[i] = 0; tv_cancel[i] = 0; tv_keyed[i] = 0;
    end
    clock_ms = 48'd1000;
    // directed: zero period, forever repeat, replace, cancel, unknown, saturation
    pending_cmds.push_back(mk(OP_CHECK, '0, '0, '0, '0, '0));
    pending_cmds.push_back(mk(OP_ADD, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                              48'hFFFF_FFFF_FFFF));
    pending_cmds.push_back(mk(OP_ADD, 32'h1, 31'd5, 16'd0, 32'd0, 48'd10));
    pending_cmds.push_back(mk(OP_ADD, 32'h2, 31'd6, 16'd2, 32'd3, 48'd10));
    pending_cmds.push_back(mk(OP_ADD, 32'h3, 31'd5, 16'd1, 32'd1, 48'd10));
    pending_cmds.push_back(mk(OP_CANCEL, '0, 31'd6, '0, '0, '0));
    pending_cmds.push_back(mk(OP_CANCEL, '0, 31'd6, '0, '0, '0));
    pending_cmds.push_back(mk(OP_CANCEL, '0, 31'd99, '0, '0, '0));
    pending_cmds.push_back(mk(OP_CHECK, '0, '0, '0, '0, 48'd11));
    pending_cmds.push_back(mk(OP_CHECK, '0, '0, '0, '0, 48'd5));
    pending_cmds.push_back(mk(OP_NOP, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                              48'hFFFF_FFFF_FFFF));
    for (int i = 0; i < 17; i++)   // fill the table past full
      pending_cmds.push_back(mk(OP_ADD, 32'(i), 31'(100 + i), 16'd0, 32'(i * 7 + 1), 48'd20));
    pending_cmds.push_back(mk(OP_CHECK, '0, '0, '0, '0, 48'd200));
    pending_cmds.push_back(mk(OP_CHECK, '0, '0, '0, '0, 48'hFFFF_FFFF_FFFF));
    for (int i = 0; i < 17; i++)
      pending_cmds.push_back(mk(OP_CANCEL, '0, 31'(100 + i), '0, '0, '0));
    pending_cmds.push_back(mk(OP_CHECK, '0, '0, '0, '0, 48'd300));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_cmds.size() == 0);
    for (int i = 0; i < 300; i++) begin
      pending_cmds.push_back(random_cmd());
      if (i == 150) begin
        // sender pause until every expected result is back
        hold_off = 1'b1;
        @(posedge clk);
        wait (!start && expected_notices.size() == 0);
        repeat (80) @(posedge clk);
        hold_off = 1'b0;
      end
      if (i == 250) no_idle = 1'b1;
    end
    wait (pending_cmds.size() == 0);
    @(posedge clk);
    wait (!start && expected_notices.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_notices.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

### repeating_timer_scheduler.f
+incdir+hw/rtl
hw/rtl/rts_pkg.sv
hw/rtl/rts_front.sv
hw/rtl/rts_back.sv
hw/rtl/repeating_timer_scheduler.sv
tb/tb_repeating_timer_scheduler.sv
